>>> rtl/md2e_pkg.sv
package md2e_pkg;

  localparam int ADDR_W      = 64;
  localparam int TYPE_W      = 32;
  localparam int PAGES_W     = 52;
  localparam int PAGE_SHIFT  = 12;
  localparam int CLASS_W     = 2;

  localparam int MAX_ENTRIES_DEFAULT = 128;

  localparam logic [ADDR_W-1:0] TOP_LIMIT_RESET = 64'h0000_0001_0000_0000;

  // Input beat kinds (tuser)
  localparam logic OP_DESC = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Firmware type codes with a class of their own
  localparam logic [TYPE_W-1:0] FW_CONVENTIONAL = 32'd7;
  localparam logic [TYPE_W-1:0] FW_ACPI_RECLAIM = 32'd9;
  localparam logic [TYPE_W-1:0] FW_ACPI_NVS     = 32'd10;

  // Map entry classes
  localparam logic [CLASS_W-1:0] CLASS_AVAIL    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_RECLAIM  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NVS      = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_RESERVED = 2'd3;

  // Descriptor after input-stage preparation
  typedef struct packed {
    logic                end_item;
    logic                empty;
    logic [CLASS_W-1:0]  cls;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   size;
    logic [ADDR_W:0]     end_sum;
  } item_t;

  // One finished result
  typedef struct packed {
    logic                entry_valid;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   length;
    logic [CLASS_W-1:0]  cls;
    logic                last;
    logic                truncated;
  } result_t;

  function automatic logic [CLASS_W-1:0] class_of(input logic [TYPE_W-1:0] code);
    logic [CLASS_W-1:0] c;
    case (code)
      FW_CONVENTIONAL: c = CLASS_AVAIL;
      FW_ACPI_RECLAIM: c = CLASS_RECLAIM;
      FW_ACPI_NVS:     c = CLASS_NVS;
      default:         c = CLASS_RESERVED;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/memory_descriptor_to_e820_merger_core.sv
// Memory descriptor to E820 merger.
//
// Slave stream: one firmware descriptor per beat; tuser = 0 for a
// descriptor, 1 for the end-of-map beat that flushes the open entry.
// Master stream: finished map entries; tlast marks the answer to the end
// beat, tuser carries entry_valid and the truncated flag.
// Config channel: write top_limit (64 bits) only while the block is idle.
//
// Throughput is one beat per cycle while the receiver keeps taking results.
// A descriptor passes through an input register (size and end sum
// computed), then the merge logic updates the open entry and loads the
// output register, which drives tvalid.
// The merge compare and length add set the critical path.
// Reset clears the open entry, the entry count and the overflow flag and
// loads top_limit with 4 GiB; both ready outputs stay low during reset.
// When the receiver stalls with a result waiting, the input register holds
// its beat and slave tready drops; a beat that yields no result still
// advances if the output register frees.
module memory_descriptor_to_e820_merger_core #(
  parameter int MAX_ENTRIES = md2e_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  // config write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [63:0]   cfg_data,       // top_limit
  // slave stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [151:0]  s_axis_tdata,   // mem_type[31:0], phys_start[95:32],
                                        // page_count[147:96], zero pad
  input  logic          s_axis_tuser,   // op
  // master stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // entry_base[63:0], entry_length[127:64],
                                        // entry_class[129:128], zero pad
  output logic [1:0]    m_axis_tuser,   // entry_valid[0], truncated[1]
  output logic          m_axis_tlast    // last
);

  logic [md2e_pkg::ADDR_W-1:0]   top_limit;

  logic                          in_valid;
  md2e_pkg::item_t               in_item;
  md2e_pkg::item_t               prep;

  logic                          out_valid;
  md2e_pkg::result_t             out_res;

  logic                          adv;
  logic                          res_fire;
  md2e_pkg::result_t             res;

  logic [md2e_pkg::PAGES_W-1:0]  pages;

  // Config register: ready outside reset; write it only while the core is idle.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_limit <= md2e_pkg::TOP_LIMIT_RESET;
    end else if (cfg_valid) begin
      top_limit <= cfg_data;
    end
  end

  // Input stage: unpack the beat, form size and the 65-bit end sum.
  assign pages = s_axis_tdata[147:96];

  always_comb begin
    prep.end_item = (s_axis_tuser == md2e_pkg::OP_END);
    prep.empty    = (pages == '0);
    prep.cls      = md2e_pkg::class_of(s_axis_tdata[31:0]);
    prep.base     = s_axis_tdata[95:32];
    prep.size     = {pages, {md2e_pkg::PAGE_SHIFT{1'b0}}};
    prep.end_sum  = {1'b0, prep.base} + {1'b0, prep.size};
  end

  // Advance the held beat whenever the output register can take a result.
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= prep;
    end
  end

  md2e_merge #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .top_limit (top_limit),
    .item_fire (adv),
    .item      (in_item),
    .res_fire  (res_fire),
    .res       (res)
  );

  // Output register: load on a result, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res.cls, out_res.length, out_res.base};
  assign m_axis_tuser  = {out_res.truncated, out_res.entry_valid};
  assign m_axis_tlast  = out_res.last;

endmodule

>>> rtl/md2e_merge.sv
module md2e_merge #(
  parameter int MAX_ENTRIES = md2e_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [md2e_pkg::ADDR_W-1:0]   top_limit,
  input  logic                          item_fire,
  input  md2e_pkg::item_t               item,
  output logic                          res_fire,
  output md2e_pkg::result_t             res
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic                             pending_valid;
  logic [md2e_pkg::ADDR_W-1:0]      pending_base;
  logic [md2e_pkg::ADDR_W-1:0]      pending_length;
  logic [md2e_pkg::ADDR_W-1:0]      pending_end;
  logic [md2e_pkg::CLASS_W-1:0]     pending_class;
  logic [CNT_W-1:0]                 entries_used;
  logic                             full_flag;

  logic                             drop;
  logic                             over;
  logic [md2e_pkg::ADDR_W-1:0]      size_clip;
  logic [md2e_pkg::ADDR_W-1:0]      end_clip;
  logic                             merge;
  logic                             table_full;

  always_comb begin
    drop       = item.empty || (item.base >= top_limit);
    over       = item.end_sum[md2e_pkg::ADDR_W] ||
                 (item.end_sum[md2e_pkg::ADDR_W-1:0] > top_limit);
    size_clip  = over ? (top_limit - item.base) : item.size;
    end_clip   = over ? top_limit : item.end_sum[md2e_pkg::ADDR_W-1:0];
    merge      = pending_valid && (pending_class == item.cls) && (pending_end == item.base);
    table_full = entries_used >= CNT_MAX;
  end

  always_comb begin
    res_fire        = 1'b0;
    res.entry_valid = pending_valid;
    res.base        = pending_valid ? pending_base : '0;
    res.length      = pending_valid ? pending_length : '0;
    res.cls         = pending_valid ? pending_class : md2e_pkg::CLASS_AVAIL;
    res.last        = 1'b0;
    res.truncated   = 1'b0;
    if (item_fire) begin
      if (item.end_item) begin
        res_fire      = 1'b1;
        res.last      = 1'b1;
        res.truncated = full_flag;
      end else if (!full_flag && !drop && !merge && !table_full) begin
        res_fire = pending_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_base   <= '0;
      pending_length <= '0;
      pending_end    <= '0;
      pending_class  <= md2e_pkg::CLASS_AVAIL;
      entries_used   <= '0;
      full_flag      <= 1'b0;
    end else if (item_fire) begin
      if (item.end_item) begin
        // close the map and start the next one
        pending_valid  <= 1'b0;
        pending_base   <= '0;
        pending_length <= '0;
        pending_end    <= '0;
        pending_class  <= md2e_pkg::CLASS_AVAIL;
        entries_used   <= '0;
        full_flag      <= 1'b0;
      end else if (!full_flag && !drop) begin
        if (merge) begin
          pending_length <= pending_length + size_clip;
          pending_end    <= end_clip;
        end else if (table_full) begin
          full_flag <= 1'b1;
        end else begin
          pending_valid  <= 1'b1;
          pending_base   <= item.base;
          pending_length <= size_clip;
          pending_end    <= end_clip;
          pending_class  <= item.cls;
          entries_used   <= entries_used + CNT_W'(1);
        end
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= CNT_MAX)
    else $error("entry count beyond table size");

  a_pending_counted: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (entries_used != '0))
    else $error("open entry not counted");

  a_full_at_limit: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> (entries_used == CNT_MAX))
    else $error("overflow flagged before table filled");

  a_end_consistent: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (pending_end == pending_base + pending_length))
    else $error("cached entry end out of step with base and length");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (item_fire && item.end_item) |=> (!pending_valid && !full_flag))
    else $error("map state survived end beat");

endmodule
